### sv/slcr_pkg.sv
// types, command table and codes for the serial line command recognizer
`default_nettype none
package slcr_pkg;

  localparam int CMD_COUNT = 9;
  localparam int CMD_MAX   = 9;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_KNOWN   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  typedef logic [CMD_COUNT-1:0] cmd_mask_t;
  typedef logic [7:0] char_t;
  typedef char_t [0:CMD_MAX-1] cmd_word_t;

  typedef struct packed {
    logic [3:0] command_index;
    logic [1:0] line_status;
    char_t      echo_byte;
    logic       echo_valid;
  } result_t;

  localparam cmd_mask_t ALL_CMDS = '1;

  localparam cmd_word_t CMD_TEXT [0:CMD_COUNT-1] = '{
    '{"e", "n", "a", "b", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "i", "s", "a", "b", "l", "e", 8'h00, 8'h00},
    '{"i", "n", "f", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "e", "r", "s", "i", "o", "n", 8'h00, 8'h00},
    '{"p", "i", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "e", "m", "_", "i", "n", "f", "o", 8'h00},
    '{"f", "w", "_", "i", "n", "f", "o", 8'h00, 8'h00},
    '{"d", "e", "v", "_", "i", "n", "f", "o", 8'h00},
    '{"b", "o", "o", "t", "_", "i", "n", "f", "o"}
  };

  localparam logic [3:0] CMD_LEN [0:CMD_COUNT-1] = '{
    4'd6, 4'd7, 4'd4, 4'd7, 4'd4, 4'd8, 4'd7, 4'd8, 4'd9
  };

  function automatic char_t cmd_char(input int unsigned idx, input logic [3:0] pos);
    char_t c;
    c = CHAR_NUL;
    if (pos < 4'(CMD_MAX)) begin
      c = CMD_TEXT[idx][pos];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/serial_line_command_recognizer.sv
// serial line command recognizer top level
`default_nettype none
// Takes one byte per clock on in_ while results are taken and returns one result item per byte
// on the out_ stream in the next cycle, through a single output register. Throughput is one
// byte per cycle; it is set by the per-byte update of the line counters and of the nine-bit
// mask of commands that still agree with the line, which is all the work a byte needs.
// A carriage return or line feed echoes a line feed and, for a non-empty line, reports
// which of the nine command words of the package table matched (status 1 with its table
// index) or that none did (status 2). Other bytes are echoed and held while the line has
// room for LINE_CAPACITY-1 bytes and dropped after that; a held zero byte ends the
// compared text. The input is ready whenever the output register is empty or being taken.
module serial_line_command_recognizer
  import slcr_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // echo_valid, echo_byte, line_status, command_index, pad
);

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] HOLD_MAX = CW'(LINE_CAPACITY - 1);

  logic [CW-1:0] held_count_r, held_count_nxt;
  logic [CW-1:0] text_length_r, text_length_nxt;
  logic          text_ended_r, text_ended_nxt;
  cmd_mask_t     match_r, match_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       result_r, result_nxt;

  logic      in_accept;
  logic      is_eol;
  cmd_mask_t keep_mask;
  cmd_mask_t hit_mask;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign is_eol    = (in_tdata == CHAR_CR) || (in_tdata == CHAR_LF);

  always_comb begin
    for (int i = 0; i < CMD_COUNT; i++) begin
      keep_mask[i] = (text_length_r < CW'(CMD_LEN[i])) &&
                     (cmd_char(i, text_length_r[3:0]) == in_tdata);
      hit_mask[i]  = match_r[i] && (text_length_r == CW'(CMD_LEN[i]));
    end
  end

  always_comb begin
    held_count_nxt  = held_count_r;
    text_length_nxt = text_length_r;
    text_ended_nxt  = text_ended_r;
    match_nxt       = match_r;
    result_nxt      = '0;
    if (is_eol) begin
      result_nxt.echo_valid = 1'b1;
      result_nxt.echo_byte  = CHAR_LF;
      if (held_count_r != '0) begin
        result_nxt.line_status = STATUS_UNKNOWN;
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
          if (hit_mask[i]) begin
            result_nxt.line_status   = STATUS_KNOWN;
            result_nxt.command_index = 4'(i);
          end
        end
      end
      held_count_nxt  = '0;
      text_length_nxt = '0;
      text_ended_nxt  = 1'b0;
      match_nxt       = ALL_CMDS;
    end else if (held_count_r < HOLD_MAX) begin
      if (!text_ended_r) begin
        if (in_tdata == CHAR_NUL) begin
          text_ended_nxt = 1'b1;
        end else begin
          match_nxt       = match_r & keep_mask;
          text_length_nxt = text_length_r + 1'b1;
        end
      end
      held_count_nxt        = held_count_r + 1'b1;
      result_nxt.echo_valid = 1'b1;
      result_nxt.echo_byte  = in_tdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r  <= '0;
      text_length_r <= '0;
      text_ended_r  <= 1'b0;
      match_r       <= ALL_CMDS;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        held_count_r  <= held_count_nxt;
        text_length_r <= text_length_nxt;
        text_ended_r  <= text_ended_nxt;
        match_r       <= match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, result_r};

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= HOLD_MAX && text_length_r <= held_count_r)
    else $error("line count out of range");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && is_eol |=> held_count_r == '0 && match_r == ALL_CMDS && !text_ended_r)
    else $error("line state not cleared after line end");

  a_status_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && result_r.line_status != STATUS_NONE |->
      result_r.echo_valid && result_r.echo_byte == CHAR_LF)
    else $error("command event without line feed echo");

  a_index_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && result_r.command_index != 4'd0 |-> result_r.line_status == STATUS_KNOWN)
    else $error("command index without known command");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted item produced no result");
`endif

endmodule
`default_nettype wire

### test/serial_line_command_recognizer_test.sv
// testbench for the serial line command recognizer: directed lines, then random lines
module serial_line_command_recognizer_test;
  import slcr_pkg::*;

  localparam int LINE_CAPACITY = 32;
  localparam int RX_ITEMS    = 1900;
  localparam int QUIET_TAIL  = 1700;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    char_t   rx;
    bit      has_want;
    result_t want;
  } row_t;

  localparam result_t NO_WANT = '0;

  localparam row_t DIRECTED [24] = '{
    '{CHAR_CR, 1'b1, '{4'd0, STATUS_NONE, CHAR_LF, 1'b1}},
    '{"i", 1'b0, NO_WANT},
    '{"n", 1'b0, NO_WANT},
    '{"f", 1'b0, NO_WANT},
    '{"o", 1'b0, NO_WANT},
    '{CHAR_LF, 1'b1, '{4'd2, STATUS_KNOWN, CHAR_LF, 1'b1}},
    '{8'hFF, 1'b0, NO_WANT},
    '{CHAR_CR, 1'b1, '{4'd0, STATUS_UNKNOWN, CHAR_LF, 1'b1}},
    '{CHAR_NUL, 1'b1, '{4'd0, STATUS_NONE, CHAR_NUL, 1'b1}},
    '{CHAR_LF, 1'b1, '{4'd0, STATUS_UNKNOWN, CHAR_LF, 1'b1}},
    '{"p", 1'b0, NO_WANT},
    '{"i", 1'b0, NO_WANT},
    '{"n", 1'b0, NO_WANT},
    '{"g", 1'b0, NO_WANT},
    '{CHAR_NUL, 1'b0, NO_WANT},
    '{"x", 1'b0, NO_WANT},
    '{CHAR_CR, 1'b1, '{4'd4, STATUS_KNOWN, CHAR_LF, 1'b1}},
    '{"i", 1'b0, NO_WANT},
    '{"n", 1'b0, NO_WANT},
    '{"f", 1'b0, NO_WANT},
    '{CHAR_LF, 1'b1, '{4'd0, STATUS_UNKNOWN, CHAR_LF, 1'b1}},
    '{8'h80, 1'b0, NO_WANT},
    '{8'h7F, 1'b0, NO_WANT},
    '{CHAR_LF, 1'b1, '{4'd0, STATUS_UNKNOWN, CHAR_LF, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  result_t   awaited_results [$];
  int        mismatch_count = 0;
  int        echoed_count   = 0;
  bit        idle_on        = 1'b1;
  bit        tx_busy        = 1'b1;

  int        line_held    = 0;
  int        compared_len = 0;
  bit        compare_done = 1'b0;
  cmd_mask_t agreeing     = ALL_CMDS;

  serial_line_command_recognizer #(.LINE_CAPACITY(LINE_CAPACITY)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t predict_line_result(input char_t rx);
    result_t r;
    r = '0;
    if (rx == CHAR_CR || rx == CHAR_LF) begin
      r.echo_valid = 1'b1;
      r.echo_byte  = CHAR_LF;
      if (line_held != 0) begin
        r.line_status = STATUS_UNKNOWN;
        // lowest table index wins
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
          if (agreeing[i] && int'(CMD_LEN[i]) == compared_len) begin
            r.line_status   = STATUS_KNOWN;
            r.command_index = 4'(i);
          end
        end
      end
      line_held    = 0;
      compared_len = 0;
      compare_done = 1'b0;
      agreeing     = ALL_CMDS;
    end else if (line_held + 1 < LINE_CAPACITY) begin
      if (!compare_done) begin
        if (rx == CHAR_NUL) begin
          compare_done = 1'b1;
        end else begin
          for (int i = 0; i < CMD_COUNT; i++) begin
            if (compared_len >= int'(CMD_LEN[i])) begin
              agreeing[i] = 1'b0;
            end else if (CMD_TEXT[i][compared_len] != rx) begin
              agreeing[i] = 1'b0;
            end
          end
          compared_len++;
        end
      end
      line_held++;
      r.echo_valid = 1'b1;
      r.echo_byte  = rx;
    end
    return r;
  endfunction

  function automatic char_t text_byte();
    char_t c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_rx(input char_t b, input bit has_want, input result_t want);
    result_t predicted;
    bit      took;
    int      gap;
    if (idle_on && tx_busy && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predicted = predict_line_result(b);
    awaited_results.push_back(has_want ? want : predicted);
    if (predicted.echo_valid) begin
      echoed_count++;
    end
  endtask

  task automatic send_random_line();
    char_t text [$];
    int    kind;
    int    pick;
    int    n;
    kind = $urandom_range(0, 9);
    pick = $urandom_range(0, CMD_COUNT - 1);
    for (int j = 0; j < int'(CMD_LEN[pick]); j++) begin
      text.push_back(CMD_TEXT[pick][j]);
    end
    case (kind)
      5: begin
        text[$urandom_range(0, text.size() - 1)] = text_byte();
      end
      6: begin
        if ($urandom_range(0, 1) == 0) begin
          text.pop_back();
        end else begin
          text.push_back(text_byte());
        end
      end
      7: begin
        text.insert($urandom_range(0, text.size()), CHAR_NUL);
        n = $urandom_range(0, 30);
        repeat (n) text.push_back(text_byte());
      end
      8: begin
        text.delete();
        n = $urandom_range(25, 45);
        repeat (n) text.push_back($urandom_range(0, 15) == 0 ? CHAR_NUL : text_byte());
      end
      9: begin
        text.delete();
        n = $urandom_range(0, 12);
        repeat (n) text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
    foreach (text[j]) send_rx(text[j], 1'b0, NO_WANT);
    send_rx($urandom_range(0, 1) == 0 ? CHAR_CR : CHAR_LF, 1'b0, NO_WANT);
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    int gap;
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && echoed_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 1) == 0 && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    result_t got;
    result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[14:0];
        if (awaited_results.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("echo_valid", int'(want.echo_valid), int'(got.echo_valid));
          check_field("echo_byte", int'(want.echo_byte), int'(got.echo_byte));
          check_field("line_status", int'(want.line_status), int'(got.line_status));
          check_field("command_index", int'(want.command_index),
                      int'(got.command_index));
          check_field("pad", 0, int'(out_tdata[15]));
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[k]) send_rx(DIRECTED[k].rx, DIRECTED[k].has_want, DIRECTED[k].want);
    while (echoed_count < RX_ITEMS) begin
      if (echoed_count >= QUIET_TAIL) begin
        idle_on = 1'b0;
      end
      tx_busy = $urandom_range(0, 2) != 0;
      send_random_line();
    end
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
